### src/rma_pkg.sv
package rma_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 7;
    localparam int USED_W   = 7;

    // quotient bits produced by the divider, one per step
    localparam int QUOT_W   = 16;

    // packed result width, padded to whole bytes
    localparam int OUT_DATA_W = 24;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd8;

endpackage

### src/rma_ram.sv
module rma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/rma_divider.sv
module rma_divider
    import rma_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [SAMPLE_W+CNT_W-1:0] dividend,
    input  logic [CNT_W-1:0]                 divisor,
    output logic                             done,
    output logic [QUOT_W-1:0]                quotient
);

    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } div_state_t;

    div_state_t          state_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]   low_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic [CNT_W-1:0]    div_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                done_reg;
    logic [QUOT_W-1:0]   quot_reg;

    logic [SUM_W-1:0]    mag;
    logic [CNT_W:0]      trial;
    logic                fits;
    logic [CNT_W-1:0]    rem_next;
    logic [QUOT_W-1:0]   q_next;

    // magnitude of the signed sum
    assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb
    begin
        trial    = {rem_reg, low_reg[QUOT_W-1]} - {1'b0, div_reg};
        fits     = ~trial[CNT_W];
        rem_next = fits ? trial[CNT_W-1:0] : {rem_reg[CNT_W-2:0], low_reg[QUOT_W-1]};
        q_next   = {q_reg[QUOT_W-2:0], fits};
    end

    // sequencer, step registers and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        // upper part is below the divisor since |mean| fits in 16 bits
                        rem_reg   <= mag[SUM_W-1:QUOT_W];
                        low_reg   <= mag[QUOT_W-1:0];
                        q_reg     <= '0;
                        div_reg   <= divisor;
                        neg_reg   <= dividend[SUM_W-1];
                        step_reg  <= '0;
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    rem_reg  <= rem_next;
                    low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
                    q_reg    <= q_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QUOT_W - 1))
                    begin
                        // truncation toward zero: negate the magnitude quotient
                        quot_reg  <= neg_reg ? QUOT_W'(-q_next) : q_next;
                        done_reg  <= 1'b1;
                        state_reg <= DV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### src/ring_moving_average.sv
// items are processed one at a time: a new item is accepted only in idle, after the
// previous result is loaded; the pace is set by the single ram read port in the
//   summing pass (one sample per cycle) and the 16-step restoring divider
// reset: rst_n asynchronous, active low; clears position, fill count and handshakes,
//   window length returns to 8; ring contents are not cleared
module ring_moving_average
    import rma_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: window_length
    input  logic                  window_wen,
    input  logic [WIN_W-1:0]      window_wdata,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [15:0] smoothed, [22:16] samples_used, [23] zero
);

    localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_HOLD
    } state_t;

    state_t                   state_reg;
    logic [WIN_W-1:0]         window_reg;
    logic [ADDR_W-1:0]        wp_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         issued_reg;
    logic                     pend_reg;
    logic [ADDR_W-1:0]        rd_addr_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     m_tvalid_reg;
    logic [SAMPLE_W-1:0]      smoothed_reg;
    logic [USED_W-1:0]        used_reg;

    logic                     accept;
    logic                     rd_en;
    logic [SAMPLE_W-1:0]      ram_rdata;
    logic [CNT_W-1:0]         fill_next;
    logic [CMP_W-1:0]         win_clamp;
    logic [CMP_W-1:0]         n_calc;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_SUM) && (issued_reg != n_reg);

    // count of samples averaged for the item being accepted
    always_comb
    begin
        fill_next = (fill_reg == CNT_W'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;
        win_clamp = CMP_W'(window_reg);
        if (win_clamp == '0)
        begin
            win_clamp = CMP_W'(1);
        end
        if (win_clamp > CMP_W'(RING_DEPTH))
        begin
            win_clamp = CMP_W'(RING_DEPTH);
        end
        n_calc = (win_clamp > CMP_W'(fill_next)) ? CMP_W'(fill_next) : win_clamp;
    end

    rma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    rma_divider #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_GO),
        .dividend (acc_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (window_wen)
        begin
            window_reg <= window_wdata;
        end
    end

    // sequencer: push, sum newest n samples backward, divide, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            fill_reg     <= '0;
            n_reg        <= '0;
            issued_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // item taken by the receiver; ST_HOLD sets its own next value
            if (m_tvalid_reg && m_tready && state_reg != ST_HOLD)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wp_reg      <= (wp_reg == ADDR_W'(RING_DEPTH - 1)) ? '0
                                                                          : wp_reg + 1'b1;
                        fill_reg    <= fill_next;
                        n_reg       <= CNT_W'(n_calc);
                        rd_addr_reg <= wp_reg;
                        issued_reg  <= '0;
                        pend_reg    <= 1'b0;
                        acc_reg     <= '0;
                        state_reg   <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    pend_reg <= rd_en;
                    if (rd_en)
                    begin
                        issued_reg  <= issued_reg + 1'b1;
                        rd_addr_reg <= (rd_addr_reg == '0) ? ADDR_W'(RING_DEPTH - 1)
                                                           : rd_addr_reg - 1'b1;
                    end
                    if (pend_reg)
                    begin
                        acc_reg <= acc_reg
                                 + {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
                    end
                    if (!rd_en && !pend_reg)
                    begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    // load the output register once the previous item is taken
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        smoothed_reg <= div_quot;
                        used_reg     <= USED_W'(n_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-USED_W-SAMPLE_W){1'b0}}, used_reg, smoothed_reg};

    // checks
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (n_reg != '0 && n_reg <= CNT_W'(RING_DEPTH)))
        else $error("averaging count out of range");

    a_fill_sat: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_accept_sum: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SUM && issued_reg == '0))
        else $error("accepted item did not start the summing pass");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (issued_reg <= n_reg))
        else $error("more reads issued than samples averaged");

endmodule
